[src/scs_pkg.sv]
// ============================================================================
// scs_pkg: shared types and constants for the servo command slew controller
// Holds the field widths, the character and channel codes, the configuration
// layout, and the structs passed between the controller's submodules.
// ============================================================================
package scs_pkg;

  // Line assembly limits and servo pulse width.
  localparam int LINE_LIMIT = 32;
  localparam int PULSE_BITS = 12;
  localparam int IDX_W      = $clog2(LINE_LIMIT);
  localparam int KEEP_CHARS = 4;
  localparam int CHAR_W     = 8;

  // Configuration port layout.
  localparam int OFFSET_W   = 12;
  localparam int SCALE_W    = 10;
  localparam int CFG_DATA_W = (PULSE_BITS > OFFSET_W) ? PULSE_BITS : OFFSET_W;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_JOINTS = 3;
  localparam int JOINT_W    = 2;
  localparam int CHAN_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CLAW_OPEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAW_CLOSED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRIST_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRIST_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_SCALE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_SCALE = 3'd7;

  // Input item kinds.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Command characters.
  localparam logic [CHAR_W-1:0] CHAR_NL       = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_OPEN     = 8'h6F;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE    = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_WRIST    = 8'h77;
  localparam logic [CHAR_W-1:0] CHAR_ELBOW    = 8'h65;
  localparam logic [CHAR_W-1:0] CHAR_SHOULDER = 8'h73;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;

  // Joint codes; JOINT_NONE marks a line that is not a joint command.
  localparam logic [JOINT_W-1:0] JOINT_WRIST    = 2'd0;
  localparam logic [JOINT_W-1:0] JOINT_ELBOW    = 2'd1;
  localparam logic [JOINT_W-1:0] JOINT_SHOULDER = 2'd2;
  localparam logic [JOINT_W-1:0] JOINT_NONE     = 2'd3;

  // Servo channels.
  localparam logic [CHAN_W-1:0] CH_CLAW     = 4'd12;
  localparam logic [CHAN_W-1:0] CH_WRIST    = 4'd13;
  localparam logic [CHAN_W-1:0] CH_ELBOW    = 4'd14;
  localparam logic [CHAN_W-1:0] CH_SHOULDER = 4'd15;

  localparam logic [PULSE_BITS-1:0] PULSE_MAX = {PULSE_BITS{1'b1}};

  // Target arithmetic widths. Digits are accumulated from the low nibble of
  // each character, so the degree value stays below 1666 for any byte.
  localparam int ACC_W  = 8;
  localparam int DEG_W  = 11;
  localparam int VAL_W  = 15;
  localparam int PROD_W = VAL_W + SCALE_W;

  // Exact floor division by 1000 for any PROD_W-bit value: drop three bits,
  // then multiply by ceil(2^29 / 125) and keep the bits above 29.
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIVQ_IN_W     = PROD_W - DIV_PRE_SHIFT;
  localparam int RECIP_W       = 23;
  localparam int RECIP_SHIFT   = 29;
  localparam int QUOT_W        = DIVQ_IN_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd4294968;

  // Position reset values.
  localparam logic [PULSE_BITS-1:0] CLAW_RESET = PULSE_BITS'(160);
  localparam logic [NUM_JOINTS-1:0][PULSE_BITS-1:0] JOINT_RESET =
      {PULSE_BITS'(120), PULSE_BITS'(340), PULSE_BITS'(570)};

  // Result codes.
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_WRITE     = 2'd1,
    EV_MALFORMED = 2'd2,
    EV_BUSY      = 2'd3
  } event_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0]                claw_open;
    logic [PULSE_BITS-1:0]                claw_closed;
    logic [NUM_JOINTS-1:0][OFFSET_W-1:0]  offset;
    logic [NUM_JOINTS-1:0][SCALE_W-1:0]   scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    claw_open:   PULSE_BITS'(120),
    claw_closed: PULSE_BITS'(160),
    offset:      {OFFSET_W'(678), OFFSET_W'(430), OFFSET_W'(750)},
    scale:       {SCALE_W'(177), SCALE_W'(250), SCALE_W'(177)}
  };

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]                  len;
    logic [KEEP_CHARS-1:0][CHAR_W-1:0] chars;
    logic [PROD_W-1:0]                 product;
  } line_info_t;

  typedef struct packed {
    event_t                ev;
    logic [CHAN_W-1:0]     channel;
    logic [PULSE_BITS-1:0] pulse;
    logic                  done;
  } res_t;

  // Maps a command character to the joint it moves.
  function automatic logic [JOINT_W-1:0] cmd_joint(input logic [CHAR_W-1:0] c);
    logic [JOINT_W-1:0] j;
    case (c)
      CHAR_WRIST:    j = JOINT_WRIST;
      CHAR_ELBOW:    j = JOINT_ELBOW;
      CHAR_SHOULDER: j = JOINT_SHOULDER;
      default:       j = JOINT_NONE;
    endcase
    return j;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

[src/scs_cfg_regs.sv]
// ============================================================================
// scs_cfg_regs: configuration register file
// Eight write-only registers holding the claw pulses and the per-joint
// offset and scale used for target conversion.
// ============================================================================
module scs_cfg_regs
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register writes; narrower registers keep the low bits of the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLAW_OPEN:       cfg_r.claw_open <= cfg_data[PULSE_BITS-1:0];
        CFG_CLAW_CLOSED:     cfg_r.claw_closed <= cfg_data[PULSE_BITS-1:0];
        CFG_WRIST_OFFSET:    cfg_r.offset[JOINT_WRIST] <= cfg_data[OFFSET_W-1:0];
        CFG_WRIST_SCALE:     cfg_r.scale[JOINT_WRIST] <= cfg_data[SCALE_W-1:0];
        CFG_ELBOW_OFFSET:    cfg_r.offset[JOINT_ELBOW] <= cfg_data[OFFSET_W-1:0];
        CFG_ELBOW_SCALE:     cfg_r.scale[JOINT_ELBOW] <= cfg_data[SCALE_W-1:0];
        CFG_SHOULDER_OFFSET: cfg_r.offset[JOINT_SHOULDER] <= cfg_data[OFFSET_W-1:0];
        CFG_SHOULDER_SCALE:  cfg_r.scale[JOINT_SHOULDER] <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/scs_line_asm.sv]
// ============================================================================
// scs_line_asm: command line assembler
// Collects the first characters of a line, tracks the saturating line
// index, and keeps the scaled product (deg*10 + offset) * scale ready so
// that the newline only has to divide it.
// ============================================================================
module scs_line_asm
  import scs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  cfg_t       cfg,
  output line_info_t info
);

  logic [IDX_W-1:0]                  idx_r;
  logic [IDX_W-1:0]                  idx_nxt;
  logic [KEEP_CHARS-1:0][CHAR_W-1:0] chars_r;
  logic [ACC_W-1:0]                  acc_r;
  logic [DEG_W-1:0]                  deg_r;
  logic [PROD_W-1:0]                 product_r;

  logic              is_char;
  logic              is_nl;
  logic [3:0]        digit;
  logic [ACC_W-1:0]  acc_next;
  logic [DEG_W-1:0]  deg_new;
  logic [DEG_W-1:0]  deg_src;
  logic              last_digit;
  logic [JOINT_W-1:0] joint;
  logic [OFFSET_W-1:0] offset_sel;
  logic [SCALE_W-1:0]  scale_sel;
  logic [VAL_W-1:0]    val;

  assign is_char = fire && (item.mode == MODE_BYTE) && (item.rx_byte != CHAR_NL);
  assign is_nl   = fire && (item.mode == MODE_BYTE) && (item.rx_byte == CHAR_NL);
  assign digit   = item.rx_byte[3:0];

  // Line index: cleared by newline, saturates one below the line limit.
  always_comb begin
    idx_nxt = idx_r;
    if (is_nl) begin
      idx_nxt = '0;
    end else if (is_char && (idx_r < IDX_W'(LINE_LIMIT - 1))) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Decimal accumulation of the argument digits, times ten by shift-add.
  assign acc_next   = ACC_W'({acc_r, 3'b000}) + ACC_W'({acc_r, 1'b0}) + ACC_W'(digit);
  assign deg_new    = DEG_W'({acc_r, 3'b000}) + DEG_W'({acc_r, 1'b0}) + DEG_W'(digit);
  assign last_digit = is_char && (idx_r == IDX_W'(KEEP_CHARS - 1));
  assign deg_src    = last_digit ? deg_new : deg_r;

  // Kept characters and digit accumulator.
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP_CHARS; i++) begin
      if (is_char && (idx_r == IDX_W'(i))) begin
        chars_r[i] <= item.rx_byte;
      end
    end
    if (is_char && (idx_r == IDX_W'(1))) begin
      acc_r <= ACC_W'(digit);
    end else if (is_char && (idx_r == IDX_W'(2))) begin
      acc_r <= acc_next;
    end
    if (last_digit) begin
      deg_r <= deg_new;
    end
  end

  // Offset and scale of the joint named by the first character.
  assign joint = cmd_joint(chars_r[0]);

  always_comb begin
    case (joint)
      JOINT_ELBOW: begin
        offset_sel = cfg.offset[JOINT_ELBOW];
        scale_sel  = cfg.scale[JOINT_ELBOW];
      end
      JOINT_SHOULDER: begin
        offset_sel = cfg.offset[JOINT_SHOULDER];
        scale_sel  = cfg.scale[JOINT_SHOULDER];
      end
      default: begin
        offset_sel = cfg.offset[JOINT_WRIST];
        scale_sel  = cfg.scale[JOINT_WRIST];
      end
    endcase
  end

  // Scaled product, refreshed every cycle so it follows configuration writes.
  assign val = VAL_W'({deg_src, 3'b000}) + VAL_W'({deg_src, 1'b0}) + VAL_W'(offset_sel);

  always_ff @(posedge clk) begin
    product_r <= PROD_W'(val) * PROD_W'(scale_sel);
  end

  assign info.len     = idx_r;
  assign info.chars   = chars_r;
  assign info.product = product_r;

endmodule

[src/scs_cmd_exec.sv]
// ============================================================================
// scs_cmd_exec: command decode and slew engine
// Finishes a line into a claw write, a new joint slew, or a malformed or
// busy report, and steps the active joint one count per slew tick.
// ============================================================================
module scs_cmd_exec
  import scs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  cfg_t       cfg,
  input  line_info_t info,
  output res_t       res
);

  logic [PULSE_BITS-1:0]                 claw_r;
  logic [PULSE_BITS-1:0]                 claw_nxt;
  logic [NUM_JOINTS-1:0][PULSE_BITS-1:0] pos_r;
  logic [NUM_JOINTS-1:0][PULSE_BITS-1:0] pos_nxt;
  logic [PULSE_BITS-1:0]                 target_r;
  logic [PULSE_BITS-1:0]                 target_nxt;
  logic [JOINT_W-1:0]                    joint_r;
  logic [JOINT_W-1:0]                    joint_nxt;
  logic                                  moving_r;
  logic                                  moving_nxt;

  logic                            is_nl;
  logic                            is_tick;
  logic [CHAR_W-1:0]               cmd_c;
  logic [JOINT_W-1:0]              cmd_j;
  logic                            is_claw_cmd;
  logic [PULSE_BITS-1:0]           claw_want;
  logic                            args_ok;
  logic [JOINT_W-1:0]              rd_sel;
  logic [PULSE_BITS-1:0]           pos_rd;
  logic [PULSE_BITS-1:0]           pos_step;
  logic [DIVQ_IN_W-1:0]            div_in;
  logic [DIVQ_IN_W+RECIP_W-1:0]    div_prod;
  logic [QUOT_W-1:0]               quot;
  logic [PULSE_BITS-1:0]           new_target;

  assign is_nl   = fire && (item.mode == MODE_BYTE) && (item.rx_byte == CHAR_NL);
  assign is_tick = fire && (item.mode == MODE_TICK);

  // Line decode.
  assign cmd_c       = info.chars[0];
  assign cmd_j       = cmd_joint(cmd_c);
  assign is_claw_cmd = (cmd_c == CHAR_OPEN) || (cmd_c == CHAR_CLOSE);
  assign claw_want   = (cmd_c == CHAR_OPEN) ? cfg.claw_open : cfg.claw_closed;
  assign args_ok     = (info.len >= IDX_W'(KEEP_CHARS)) && is_digit(info.chars[1]) &&
                       is_digit(info.chars[2]) && is_digit(info.chars[3]);

  // Floor division of the scaled product by 1000, then 12-bit saturation.
  assign div_in     = info.product[PROD_W-1:DIV_PRE_SHIFT];
  assign div_prod   = (DIVQ_IN_W+RECIP_W)'(div_in) * (DIVQ_IN_W+RECIP_W)'(RECIP_MUL);
  assign quot       = div_prod[RECIP_SHIFT +: QUOT_W];
  assign new_target = (quot > QUOT_W'(PULSE_MAX)) ? PULSE_MAX : quot[PULSE_BITS-1:0];

  // One joint position is read per item: the active joint on a tick, the
  // commanded joint on a newline.
  assign rd_sel = is_tick ? joint_r : cmd_j;

  always_comb begin
    pos_rd = pos_r[JOINT_WRIST];
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if (rd_sel == JOINT_W'(i)) begin
        pos_rd = pos_r[i];
      end
    end
  end

  // One count toward the target.
  always_comb begin
    if (pos_rd < target_r) begin
      pos_step = pos_rd + 1'b1;
    end else if (pos_rd > target_r) begin
      pos_step = pos_rd - 1'b1;
    end else begin
      pos_step = pos_rd;
    end
  end

  // Next state and the result of this transaction.
  always_comb begin
    claw_nxt   = claw_r;
    pos_nxt    = pos_r;
    target_nxt = target_r;
    joint_nxt  = joint_r;
    moving_nxt = moving_r;
    res        = '0;
    res.ev     = EV_NONE;
    if (is_nl && (info.len != '0)) begin
      if (is_claw_cmd) begin
        if (moving_r) begin
          res.ev = EV_BUSY;
        end else if (claw_r != claw_want) begin
          claw_nxt    = claw_want;
          res.ev      = EV_WRITE;
          res.channel = CH_CLAW;
          res.pulse   = claw_want;
          res.done    = 1'b1;
        end
      end else if (cmd_j != JOINT_NONE) begin
        if (moving_r) begin
          res.ev = EV_BUSY;
        end else if (!args_ok) begin
          res.ev = EV_MALFORMED;
        end else if (new_target != pos_rd) begin
          target_nxt = new_target;
          joint_nxt  = cmd_j;
          moving_nxt = 1'b1;
        end
      end
    end else if (is_tick && moving_r) begin
      if (joint_r == JOINT_NONE) begin
        moving_nxt = 1'b0;
      end else begin
        for (int i = 0; i < NUM_JOINTS; i++) begin
          if (joint_r == JOINT_W'(i)) begin
            pos_nxt[i] = pos_step;
          end
        end
        if (pos_step == target_r) begin
          moving_nxt = 1'b0;
        end
        res.ev      = EV_WRITE;
        res.channel = CH_WRIST + CHAN_W'(joint_r);
        res.pulse   = pos_step;
        res.done    = (pos_step == target_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      claw_r   <= CLAW_RESET;
      pos_r    <= JOINT_RESET;
      target_r <= '0;
      joint_r  <= JOINT_WRIST;
      moving_r <= 1'b0;
    end else begin
      claw_r   <= claw_nxt;
      pos_r    <= pos_nxt;
      target_r <= target_nxt;
      joint_r  <= joint_nxt;
      moving_r <= moving_nxt;
    end
  end

endmodule

[src/servo_command_slew_controller_top.sv]
// ============================================================================
// servo_command_slew_controller_top: serial command to servo slew controller
// Registers each byte or slew tick, decodes it in one pass, and presents one
// result transaction per input transaction from a result register.
// ============================================================================
//
//  Channel  Ports                                         Direction
//  -------  --------------------------------------------  ---------
//  in       in_valid, in_stall, in_mode, in_rx_byte       receive
//  out      out_valid, out_stall, out_event_res,          send
//           out_channel, out_pulse, out_move_done
//  cfg      cfg_we, cfg_index, cfg_data                   receive
//
//  One transaction per clock is sustained while out_stall and cfg_we are low; the
//  limit is the single pass from the input register through the divide-by-1000
//  multiplier to the result register, from which each result is presented.
//  Reset (rst_n low at a clock edge) clears the valid flags and the line
//  index, and returns positions, slew state and configuration to defaults.
//  in_stall is high while out_stall holds back a full pipeline or cfg_we is high.
//
module servo_command_slew_controller_top
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [CHAR_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_res,
  output logic [CHAN_W-1:0]     out_channel,
  output logic [PULSE_BITS-1:0] out_pulse,
  output logic                  out_move_done
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  item_t      s1_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_t       out_res_r;

  logic       advance;
  logic       fire;
  logic       in_fire;
  cfg_t       cfg;
  line_info_t info;
  res_t       res;

  // Pipeline handshake: stage one moves on when the result register frees.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = cfg_we || (s1_valid_r && !advance);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode    <= in_mode;
      s1_item_r.rx_byte <= in_rx_byte;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  scs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scs_line_asm u_line_asm (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .info  (info)
  );

  scs_cmd_exec u_cmd_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .info  (info),
    .res   (res)
  );

  assign out_valid     = out_valid_r;
  assign out_event_res = out_res_r.ev;
  assign out_channel   = out_res_r.channel;
  assign out_pulse     = out_res_r.pulse;
  assign out_move_done = out_res_r.done;

`ifndef ASSERT_OFF
  // Only a servo write carries a channel, a pulse or a done flag.
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_WRITE) |->
      (out_channel == '0) && (out_pulse == '0) && !out_move_done)
    else $error("non-write result carries payload");

  // A claw write always lands on its target.
  a_claw_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_WRITE) && (out_channel == CH_CLAW) |->
      out_move_done)
    else $error("claw write without done");

  // Writes only go to the four arm channels.
  a_write_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_WRITE) |->
      (out_channel == CH_CLAW) || (out_channel == CH_WRIST) ||
      (out_channel == CH_ELBOW) || (out_channel == CH_SHOULDER))
    else $error("write to an unexpected channel");

  // A processed transaction shows up in the result register next cycle.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed transaction produced no result");

  // No input transaction is taken during a configuration write.
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_stall)
    else $error("input taken during configuration write");
`endif

endmodule
